/* hdl/gfa_pkg.sv */
// shared types and constants of the gravity force accumulator
package gfa_pkg;

  // input item: one body paired with one attracting sun
  typedef struct packed {
    logic signed [31:0] body_x;
    logic signed [31:0] body_y;
    logic        [23:0] body_mass;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic               last_source;
  } in_item_t;

  // result item: summed force of one body
  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic               saturated;
  } out_item_t;

  localparam int unsigned MUL_W   = 33;   // multiplier operand width
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned REM_W   = 100;  // compare-subtract width
  localparam int unsigned DEN_W   = 99;   // r^3
  localparam int unsigned NUM_W   = 81;   // masses times offset
  localparam int unsigned QUO_W   = 47;   // unclipped quotient bits
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 6;

  localparam logic [CNT_W-1:0] SQRT_LAST_STEP = CNT_W'(32);
  localparam logic [CNT_W-1:0] DIV_LAST_STEP  = CNT_W'(QUO_W - 1);

  localparam logic [23:0]       SUN_MASS_RST = 24'd10000;
  localparam logic [SUM_W-1:0]  POS_MAX      = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  NEG_MIN      = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

/* hdl/gravity_force_accumulator_core.sv */
// top level of the gravity force accumulator: sequencer and datapath registers
//
// Each item pairs one body with one sun and adds the pull
// sun_mass * body_mass * d / |d|^3 (d = sun - body, positions in Q23.8) to an
// x/y accumulator; on an item with last_source set the summed force (Q39.8,
// saturated, with a flag if anything clipped) is emitted and the sum cleared.
// One item is worked on at a time. The square root and the two divisions, one
// per component, run one bit a cycle through the single compare-subtract unit;
// the products use the one shared 33x33 multiplier. A component whose pull
// clips skips its division; a zero offset goes straight to the final step. A
// result waits in an output register; the final step of a last-sun item holds
// until that register is free.
module gravity_force_accumulator_core
  import gfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  typedef enum logic [18:0] {
    ST_IDLE     = 19'd1,
    ST_PREP     = 19'd2,
    ST_MUL_XX   = 19'd4,
    ST_MUL_YY   = 19'd8,
    ST_SUM_S2   = 19'd16,
    ST_SQRT     = 19'd32,
    ST_MUL_RR   = 19'd64,
    ST_R2_LO    = 19'd128,
    ST_R2_HI    = 19'd256,
    ST_MASS     = 19'd512,
    ST_MASS_W   = 19'd1024,
    ST_NUM_LO   = 19'd2048,
    ST_NUM_HI   = 19'd4096,
    ST_NUM_ADD  = 19'd8192,
    ST_DIV_INIT = 19'd16384,
    ST_DIV      = 19'd32768,
    ST_TERM     = 19'd65536,
    ST_ACC      = 19'd131072,
    ST_FIN      = 19'd262144
  } state_e;

  state_e state_q, state_d;

  // control
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             comp_q, comp_d;       // 0 while working on x, 1 on y
  logic [23:0]      sun_mass_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_x_d;
  logic signed [SUM_W-1:0] sum_y_q, sum_y_d;
  logic             clip_q, clip_d;
  logic             out_valid_q;
  logic             out_load;
  logic             out_free;

  // datapath
  logic signed [32:0]   dx_q, dy_q;       // exact raw offsets
  logic [MUL_W-1:0]     ax_q, ay_q;       // offset magnitudes
  logic [23:0]          bmass_q;
  logic                 last_q;
  logic [PROD_W-1:0]    s2_q;             // squared distance, shifted during sqrt
  logic [MUL_W-1:0]     root_q;
  logic [MUL_W-1:0]     r2hi_q;
  logic [DEN_W-1:0]     den_q;            // r^3
  logic [47:0]          mm_q;             // sun_mass * body_mass
  logic [NUM_W-1:0]     num_q;            // mm * |d|
  logic [REM_W-1:0]     rem_q;
  logic [QUO_W-1:0]     bits_q;           // numerator bits still to shift in
  logic [QUO_W-1:0]     quo_q;
  logic signed [SUM_W-1:0] term_q;
  out_item_t            out_q;

  // shared units
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  cs_a, cs_b, cs_diff;
  logic              cs_ge;

  logic [MUL_W-1:0]  a_sel;
  logic              neg_sel;
  logic              pull_clip;
  logic signed [SUM_W:0]   acc_sum;
  logic signed [SUM_W-1:0] acc_sel;
  logic signed [SUM_W-1:0] acc_sat;
  logic              acc_ovf;

  gfa_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  gfa_csub u_csub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .ge_o   (cs_ge),
    .diff_o (cs_diff)
  );

  assign a_sel   = comp_q ? ay_q : ax_q;
  assign neg_sel = comp_q ? dy_q[32] : dx_q[32];

  // pull term clips when num * 2^24 >= r^3 * 2^47
  assign pull_clip = {41'b0, num_q} >= {den_q, 23'b0};

  // saturating accumulate of the current component
  assign acc_sel = comp_q ? sum_y_q : sum_x_q;
  assign acc_sum = {acc_sel[SUM_W-1], acc_sel} + {term_q[SUM_W-1], term_q};
  assign acc_ovf = acc_sum[SUM_W] != acc_sum[SUM_W-1];
  assign acc_sat = acc_ovf ? (acc_sum[SUM_W] ? NEG_MIN : POS_MAX)
                           : acc_sum[SUM_W-1:0];

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign out_load = (state_q == ST_FIN) && last_q && out_free;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MUL_XX: begin mul_a = ax_q;          mul_b = ax_q;   end
      ST_MUL_YY: begin mul_a = ay_q;          mul_b = ay_q;   end
      ST_MUL_RR: begin mul_a = root_q;        mul_b = root_q; end
      ST_R2_LO:  begin mul_a = prod[MUL_W-1:0]; mul_b = root_q; end
      ST_R2_HI:  begin mul_a = r2hi_q;        mul_b = root_q; end
      ST_MASS:   begin
        mul_a = {9'b0, sun_mass_q};
        mul_b = {9'b0, bmass_q};
      end
      ST_NUM_LO: begin mul_a = mm_q[32:0];    mul_b = a_sel;  end
      ST_NUM_HI: begin mul_a = {18'b0, mm_q[47:33]}; mul_b = a_sel; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // compare-subtract operands: root digit pairs or divider bits
  always_comb begin
    if (state_q == ST_SQRT) begin
      cs_a = {rem_q[REM_W-3:0], s2_q[PROD_W-1:PROD_W-2]};
      cs_b = {65'b0, root_q, 2'b01};
    end else begin
      cs_a = {rem_q[REM_W-2:0], bits_q[QUO_W-1]};
      cs_b = {1'b0, den_q};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    clip_d  = clip_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        comp_d = 1'b0;
        // zero offset adds nothing
        if (dx_q == '0 && dy_q == '0) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_MUL_XX;
        end
      end
      ST_MUL_XX: state_d = ST_MUL_YY;
      ST_MUL_YY: state_d = ST_SUM_S2;
      ST_SUM_S2: begin
        cnt_d   = SQRT_LAST_STEP;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_MUL_RR;
        end
      end
      ST_MUL_RR: state_d = ST_R2_LO;
      ST_R2_LO:  state_d = ST_R2_HI;
      ST_R2_HI:  state_d = ST_MASS;
      ST_MASS:   state_d = ST_MASS_W;
      ST_MASS_W: state_d = ST_NUM_LO;
      ST_NUM_LO: state_d = ST_NUM_HI;
      ST_NUM_HI: state_d = ST_NUM_ADD;
      ST_NUM_ADD: state_d = ST_DIV_INIT;
      ST_DIV_INIT: begin
        cnt_d = DIV_LAST_STEP;
        if (pull_clip) begin
          clip_d  = 1'b1;
          state_d = ST_TERM;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_TERM;
        end
      end
      ST_TERM: state_d = ST_ACC;
      ST_ACC: begin
        if (acc_ovf) begin
          clip_d = 1'b1;
        end
        if (comp_q) begin
          sum_y_d = acc_sat;
          state_d = ST_FIN;
        end else begin
          sum_x_d = acc_sat;
          comp_d  = 1'b1;
          state_d = ST_NUM_LO;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          sum_x_d = '0;
          sum_y_d = '0;
          clip_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= 1'b0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      clip_q      <= 1'b0;
      sun_mass_q  <= SUN_MASS_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      clip_q  <= clip_d;
      if (cfg_we_i) begin
        sun_mass_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        dx_q    <= {in_item_i.source_x[31], in_item_i.source_x}
                 - {in_item_i.body_x[31], in_item_i.body_x};
        dy_q    <= {in_item_i.source_y[31], in_item_i.source_y}
                 - {in_item_i.body_y[31], in_item_i.body_y};
        bmass_q <= in_item_i.body_mass;
        last_q  <= in_item_i.last_source;
      end
      ST_PREP: begin
        ax_q <= dx_q[32] ? MUL_W'(-dx_q) : MUL_W'(dx_q);
        ay_q <= dy_q[32] ? MUL_W'(-dy_q) : MUL_W'(dy_q);
      end
      ST_MUL_YY: s2_q <= prod;
      ST_SUM_S2: begin
        s2_q   <= s2_q + prod;
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        rem_q  <= cs_ge ? cs_diff : cs_a;
        root_q <= {root_q[MUL_W-2:0], cs_ge};
        s2_q   <= {s2_q[PROD_W-3:0], 2'b00};
      end
      ST_R2_LO: r2hi_q <= prod[PROD_W-1:MUL_W];
      ST_R2_HI: den_q  <= DEN_W'(prod);
      ST_MASS:  den_q  <= den_q + {prod[PROD_W-1:0], 33'b0};
      ST_MASS_W: mm_q  <= prod[47:0];
      ST_NUM_HI: num_q <= NUM_W'(prod);
      ST_NUM_ADD: num_q <= num_q + {prod[47:0], 33'b0};
      ST_DIV_INIT: begin
        rem_q  <= {42'b0, num_q[NUM_W-1:23]};
        bits_q <= {num_q[22:0], 24'b0};
        quo_q  <= pull_clip ? {QUO_W{1'b1}} : '0;
      end
      ST_DIV: begin
        rem_q  <= cs_ge ? cs_diff : cs_a;
        quo_q  <= {quo_q[QUO_W-2:0], cs_ge};
        bits_q <= {bits_q[QUO_W-2:0], 1'b0};
      end
      ST_TERM: begin
        term_q <= neg_sel ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
      end
      ST_FIN: begin
        if (out_load) begin
          out_q.force_x   <= sum_x_q;
          out_q.force_y   <= sum_y_q;
          out_q.saturated <= clip_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  // an accepted item always starts with the offset step
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_PREP)
    else $error("accepted item did not enter offset step");

  // a new result only follows the final step of a last-sun item
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN && last_q))
    else $error("result raised outside final step");

  // the accumulator is empty after an emit
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> sum_x_q == '0 && sum_y_q == '0 && !clip_q)
    else $error("accumulator not cleared after emit");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < {1'b0, den_q})
    else $error("divider remainder out of range");

  // a result waiting under stall is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

/* hdl/gfa_mul.sv */
// registered 33x33 unsigned multiplier shared by all product steps
module gfa_mul
  import gfa_pkg::*;
(
  input  logic              clk_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

/* hdl/gfa_csub.sv */
// compare-subtract step shared by the square root and the divider
module gfa_csub
  import gfa_pkg::*;
(
  input  logic [REM_W-1:0] a_i,
  input  logic [REM_W-1:0] b_i,
  output logic             ge_o,
  output logic [REM_W-1:0] diff_o
);

  logic [REM_W:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~full[REM_W];
  assign diff_o = full[REM_W-1:0];

endmodule

/* tb/sv/gravity_force_accumulator_checker.sv */
// checker of the gravity force accumulator: sun pull predictor and result compare
module gravity_force_accumulator_checker
  import gfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int          pending_o,
  output int          errors_o
);

  logic        [23:0] sun_mass_q;
  logic signed [47:0] sum_x_q;
  logic signed [47:0] sum_y_q;
  logic               clipped_q;
  out_item_t          pending_forces[$];
  int                 due_cnt      = 0;
  int                 mismatch_cnt = 0;

  assign pending_o = due_cnt;
  assign errors_o  = mismatch_cnt;

  // floor of the square root, one result bit per step from the top
  function automatic logic [32:0] int_sqrt(input logic [65:0] radicand);
    logic [32:0] root;
    logic [32:0] trial;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = root | (33'd1 << b);
      if (66'(trial) * 66'(trial) <= radicand) root = trial;
    end
    return root;
  endfunction

  // masses * |d| * 2^24 / r^3, magnitude clipped to the positive limit
  function automatic logic signed [47:0] pull_component(input logic signed [32:0] d,
                                                        input logic [47:0] masses,
                                                        input logic [98:0] r_cubed,
                                                        output logic clip);
    logic [32:0]  mag;
    logic [127:0] quo;
    logic [47:0]  m;
    mag  = d[32] ? 33'(-d) : 33'(d);
    quo  = ((128'(masses) * 128'(mag)) << 24) / 128'(r_cubed);
    clip = quo > 128'(POS_MAX);
    m    = clip ? POS_MAX : quo[47:0];
    return d[32] ? -m : m;
  endfunction

  function automatic logic signed [47:0] sat_sum(input logic signed [47:0] a,
                                                 input logic signed [47:0] b,
                                                 output logic clip);
    logic signed [48:0] s;
    s    = {a[47], a} + {b[47], b};
    clip = s[48] != s[47];
    if (!clip) return s[47:0];
    return s[48] ? NEG_MIN : POS_MAX;
  endfunction

  task automatic add_sun_pull(input in_item_t it);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic        [32:0] ax;
    logic        [32:0] ay;
    logic        [32:0] r;
    logic        [98:0] r_cubed;
    logic        [47:0] masses;
    logic signed [47:0] px;
    logic signed [47:0] py;
    logic               c0, c1, c2, c3;
    out_item_t          res;
    dx = {it.source_x[31], it.source_x} - {it.body_x[31], it.body_x};
    dy = {it.source_y[31], it.source_y} - {it.body_y[31], it.body_y};
    // a sun on top of the body pulls nothing
    if (dx != 0 || dy != 0) begin
      ax        = dx[32] ? 33'(-dx) : 33'(dx);
      ay        = dy[32] ? 33'(-dy) : 33'(dy);
      r         = int_sqrt(66'(ax) * 66'(ax) + 66'(ay) * 66'(ay));
      r_cubed   = 99'(r) * 99'(r) * 99'(r);
      masses    = 48'(sun_mass_q) * 48'(it.body_mass);
      px        = pull_component(dx, masses, r_cubed, c0);
      py        = pull_component(dy, masses, r_cubed, c2);
      sum_x_q   = sat_sum(sum_x_q, px, c1);
      sum_y_q   = sat_sum(sum_y_q, py, c3);
      clipped_q = clipped_q | c0 | c1 | c2 | c3;
    end
    if (it.last_source) begin
      res.force_x    = sum_x_q;
      res.force_y    = sum_y_q;
      res.saturated  = clipped_q;
      pending_forces = {pending_forces, res};
      sum_x_q   = '0;
      sum_y_q   = '0;
      clipped_q = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: force result mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_forces.size() == 0) begin
      report_mismatch("unrequested result", 1, 0);
      return;
    end
    want = pending_forces.pop_front();
    if (got.force_x !== want.force_x) report_mismatch("force_x", got.force_x, want.force_x);
    if (got.force_y !== want.force_y) report_mismatch("force_y", got.force_y, want.force_y);
    if (got.saturated !== want.saturated)
      report_mismatch("saturated", got.saturated, want.saturated);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sun_mass_q = SUN_MASS_RST;
      sum_x_q    = '0;
      sum_y_q    = '0;
      clipped_q  = 1'b0;
      pending_forces.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) add_sun_pull(in_item_i);
      if (cfg_we_i) sun_mass_q = cfg_wdata_i;
    end
    due_cnt = pending_forces.size();
  end

endmodule

/* tb/sv/gravity_force_accumulator_core_tb.sv */
// testbench top of the gravity force accumulator: stimulus, handshakes and verdict
module gravity_force_accumulator_core_tb
  import gfa_pkg::*;
();

  // idle time after the last result before touching sun_mass or ending;
  // long enough to cover an item still in flight
  localparam int          SETTLE_CYCLES = 200;
  localparam logic [23:0] MASS_MAX      = 24'hFF_FFFF;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        pending;
  int        errors;

  // percentage of cycles in which the sender holds back / the receiver stalls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gravity_force_accumulator_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  gravity_force_accumulator_checker i_force_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // receiver side: stall decided fresh every cycle, off when the rate is zero
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic in_item_t make_pair(input logic [31:0] bx, input logic [31:0] by,
                                         input logic [23:0] bm, input logic [31:0] sx,
                                         input logic [31:0] sy, input logic last);
    in_item_t it;
    it.body_x      = bx;
    it.body_y      = by;
    it.body_mass   = bm;
    it.source_x    = sx;
    it.source_y    = sy;
    it.last_source = last;
    return it;
  endfunction

  // random signed offset in [-2^k, 2^k]
  function automatic logic [31:0] near_offset(input int unsigned k);
    return $urandom_range(0, 32'd2 << k) - (32'd1 << k);
  endfunction

  // present one item and hold it until the block takes it;
  // valid only drops when the sender decides to idle, never while stalled
  task automatic send_pair(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pauses until every pending result is out, then lets the block settle
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only called right after a drain, so the block is idle
  task automatic write_sun_mass(input logic [23:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one body against a run of suns, the final one flagged last;
  // mostly nearby suns at random scales, some on top of the body, some far off,
  // and now and then the body mass changes in the middle of the run
  task automatic send_body(input int n_suns);
    logic [31:0] bx, by, sx, sy;
    logic [23:0] bm;
    case ($urandom_range(2))
      0: begin
        bx = $urandom();
        by = $urandom();
      end
      1: begin
        bx = near_offset(20);
        by = near_offset(20);
      end
      default: begin
        bx = near_offset(8);
        by = near_offset(8);
      end
    endcase
    case ($urandom_range(4))
      0:       bm = MASS_MAX;
      1:       bm = 24'($urandom_range(0, 1));
      2:       bm = 24'($urandom_range(0, 255));
      default: bm = 24'($urandom());
    endcase
    for (int i = 0; i < n_suns; i++) begin
      case ($urandom_range(7))
        0: begin
          // sun on top of the body
          sx = bx;
          sy = by;
        end
        1: begin
          sx = $urandom();
          sy = $urandom();
        end
        default: begin
          sx = bx + near_offset($urandom_range(0, 24));
          sy = by + near_offset($urandom_range(0, 24));
        end
      endcase
      if ($urandom_range(9) == 0) bm = 24'($urandom());
      send_pair(make_pair(bx, by, bm, sx, sy, i == n_suns - 1));
    end
  endtask

  // whole bodies only, so every phase closes on an emitting item
  task automatic run_phase(input int n_items, input int send_pct, input int stall_pct);
    int sent;
    int n;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      n = $urandom_range(1, 6);
      send_body(n);
      sent += n;
    end
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset sun mass
    // sun paired with itself, emits a zero force
    send_pair(make_pair(32'd1000, -32'd77, 24'd5, 32'd1000, -32'd77, 1'b1));
    // unit distance along +x, then a zero offset mid-body, then -y and emit
    send_pair(make_pair('0, '0, 24'd1, 32'd256, '0, 1'b0));
    send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 24'd1, 32'h8000_0000,
                        32'h8000_0000, 1'b0));
    send_pair(make_pair('0, '0, 24'd1, '0, -32'd256, 1'b1));
    // corner to corner, largest possible offsets
    send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, MASS_MAX, 32'h7FFF_FFFF,
                        32'h8000_0000, 1'b1));
    send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, '0, 32'h8000_0000,
                        32'h7FFF_FFFF, 1'b1));
    // one raw step apart with the heaviest body: the pair term clips
    send_pair(make_pair(32'd5, 32'd5, MASS_MAX, 32'd6, 32'd5, 1'b0));
    send_pair(make_pair(32'd5, 32'd5, MASS_MAX, 32'd5, 32'd4, 1'b1));
    // the clip flag must be gone after the emit
    send_pair(make_pair(32'd9, 32'd9, MASS_MAX, 32'd9, 32'd9, 1'b1));
    send_pair(make_pair(32'h1234_5678, 32'h8765_4321, 24'hA5_5A5A, 32'h1234_9678,
                        32'h8765_0321, 1'b1));
    drain();

    // heaviest suns: pulls just under the limit pile up past it
    write_sun_mass(MASS_MAX);
    repeat (2) send_pair(make_pair('0, '0, MASS_MAX, 32'd7000, '0, 1'b0));
    send_pair(make_pair('0, '0, MASS_MAX, 32'd7000, '0, 1'b1));
    repeat (2) send_pair(make_pair('0, '0, MASS_MAX, '0, -32'd7000, 1'b0));
    send_pair(make_pair('0, '0, MASS_MAX, '0, -32'd7000, 1'b1));
    // saturate high, then pull back down from the limit
    repeat (2) send_pair(make_pair('0, '0, MASS_MAX, 32'd7000, '0, 1'b0));
    send_pair(make_pair('0, '0, MASS_MAX, -32'd7000, '0, 1'b1));
    drain();

    // random part, one sun mass and one idling pattern per phase
    run_phase(300, 0, 0);
    write_sun_mass(24'($urandom_range(2, 24'hFF_FFFD)));
    run_phase(400, 70, 0);
    write_sun_mass('0);
    run_phase(200, 38, 38);
    write_sun_mass(24'd1);
    run_phase(300, 0, 70);
    write_sun_mass(SUN_MASS_RST);
    run_phase(300, 38, 38);
    write_sun_mass(24'($urandom()));
    run_phase(300, 70, 70);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
